// File: rtl/rolling_hash_string_matcher_macros.svh
// Assertion helpers for the string matcher.
// Both expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef ROLLING_HASH_STRING_MATCHER_MACROS_SVH
`define ROLLING_HASH_STRING_MATCHER_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define RHSM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Expression must never be true out of reset.
`define RHSM_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// File: rtl/rhsm_pkg.sv
`default_nettype none

package rhsm_pkg;

	// Sizes
	localparam int MAX_PATTERN = 256;
	localparam int CFG_W       = 9;
	localparam int BYTE_W      = 8;
	localparam int HASH_W      = 32;
	localparam int ADDR_W      = $clog2(MAX_PATTERN);
	// holds ptr + MAX_PATTERN - m without overflow
	localparam int SUM_W       = ((ADDR_W > CFG_W) ? ADDR_W : CFG_W) + 1;

	localparam logic [HASH_W-1:0] HASH_BASE = 32'd257;
	localparam logic [HASH_W-1:0] SAT32     = 32'hFFFF_FFFF;

	// Input func codes
	localparam logic FUNC_PATTERN = 1'b0;
	localparam logic FUNC_TEXT    = 1'b1;

	// Result kind codes
	localparam logic KIND_MATCH = 1'b0;
	localparam logic KIND_TOTAL = 1'b1;

	// Effective pattern length: 0 acts as 1, clamp to MAX_PATTERN
	function automatic logic [CFG_W-1:0] eff_len(input logic [CFG_W-1:0] len);
		logic [CFG_W-1:0] r;
		if (len == '0)
			r = CFG_W'(1);
		else if (32'(len) > MAX_PATTERN)
			r = CFG_W'(MAX_PATTERN);
		else
			r = len;
		return r;
	endfunction

	// Circular window address ptr - m, modulo MAX_PATTERN (1 <= m <= MAX_PATTERN)
	function automatic logic [ADDR_W-1:0] wrap_sub(input logic [ADDR_W-1:0] ptr,
			input logic [CFG_W-1:0] m);
		logic [SUM_W-1:0] s;
		s = SUM_W'(ptr) + SUM_W'(MAX_PATTERN) - SUM_W'(m);
		if (s >= SUM_W'(MAX_PATTERN))
			s = s - SUM_W'(MAX_PATTERN);
		return ADDR_W'(s);
	endfunction

	// Circular increment
	function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] ptr);
		logic [ADDR_W-1:0] r;
		if (32'(ptr) == MAX_PATTERN - 1)
			r = '0;
		else
			r = ptr + ADDR_W'(1);
		return r;
	endfunction

	// Saturating 32-bit increment
	function automatic logic [HASH_W-1:0] sat_inc(input logic [HASH_W-1:0] v);
		return (v == SAT32) ? v : v + HASH_W'(1);
	endfunction

endpackage

`default_nettype wire

// File: rtl/rolling_hash_string_matcher.sv
// Pattern byte: accepted back to back; it updates no result.
// Text byte: accept with window read, hash update, hash compare; end of text adds an end emit.
// A hash hit adds a verify pass: pattern and window memories are read one byte per cycle.
// Results leave through a one-entry output register; the next byte is taken while it waits.
// arst_n clears length to 1, hashes, factor, counters and pointers; the two byte
// memories are not cleared (an entry is only used after it has been written).
`default_nettype none

module rolling_hash_string_matcher (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input requests
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        func,
	input  wire logic [7:0]  data,
	input  wire logic        end_of_text,
	// result requests
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             kind,
	output logic [31:0]      position,
	output logic [31:0]      total,
	output logic             last_of_run,
	// pattern length register
	input  wire logic        cfg_wr_en,
	input  wire logic [8:0]  cfg_wr_data
);

	`include "rolling_hash_string_matcher_macros.svh"

	localparam int AW = rhsm_pkg::ADDR_W;
	localparam int CW = rhsm_pkg::CFG_W;
	localparam int HW = rhsm_pkg::HASH_W;
	localparam int BW = rhsm_pkg::BYTE_W;

	// Sequencer states
	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_TEXT     = 3'd1;
	localparam logic [2:0] S_CHECK    = 3'd2;
	localparam logic [2:0] S_VERIFY   = 3'd3;
	localparam logic [2:0] S_EMIT_HIT = 3'd4;
	localparam logic [2:0] S_EMIT_END = 3'd5;

	logic [2:0]    state_q;
	logic [CW-1:0] len_q;
	logic [HW-1:0] ph_q;
	logic [HW-1:0] wh_q;
	logic [HW-1:0] factor_q;
	logic [CW-1:0] loaded_q;
	logic [HW-1:0] tidx_q;
	logic [HW-1:0] mcnt_q;
	logic [AW-1:0] wr_ptr_q;
	logic [BW-1:0] b_q;
	logic          eot_q;
	logic [CW-1:0] vk_q;
	logic [AW-1:0] va_q;
	logic          cmp_vld_s1;
	logic          cmp_last_s1;
	logic          out_valid_q;
	logic          kind_q;
	logic [HW-1:0] pos_q;
	logic [HW-1:0] total_q;
	logic          last_q;

	// Byte memories
	logic [BW-1:0] pat_mem [rhsm_pkg::MAX_PATTERN];
	logic [BW-1:0] win_mem [rhsm_pkg::MAX_PATTERN];
	logic [BW-1:0] pat_rd_q;
	logic [BW-1:0] win_rd_q;

	logic [CW-1:0] m_eff;
	logic          in_acc;
	logic          out_free;
	logic          pat_we;
	logic          txt_acc;
	logic          issue;
	logic          win_re;
	logic [AW-1:0] win_ra;
	logic          full_before;
	logic [BW-1:0] outgoing;
	logic [HW-1:0] wh_next;
	logic          cand;
	logic          load_hit;
	logic          load_end;

	assign m_eff    = rhsm_pkg::eff_len(len_q);
	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign pat_we  = in_acc && (func == rhsm_pkg::FUNC_PATTERN) && (tidx_q == '0)
		&& (loaded_q < m_eff);
	assign txt_acc = in_acc && (func == rhsm_pkg::FUNC_TEXT);
	assign issue   = (state_q == S_VERIFY) && (vk_q < m_eff);

	// Window read: outgoing byte on accept, window bytes during verify
	assign win_re = txt_acc || issue;
	assign win_ra = (state_q == S_VERIFY) ? va_q : rhsm_pkg::wrap_sub(wr_ptr_q, m_eff);

	// Rolling hash: h*257 + in - factor*out
	assign full_before = (tidx_q >= HW'(m_eff));
	assign outgoing    = full_before ? win_rd_q : '0;
	assign wh_next     = wh_q * rhsm_pkg::HASH_BASE + HW'(b_q) - factor_q * HW'(outgoing);

	assign cand = (tidx_q >= HW'(m_eff)) && (loaded_q == m_eff) && (wh_q == ph_q);

	assign load_hit = (state_q == S_EMIT_HIT) && out_free;
	assign load_end = (state_q == S_EMIT_END) && out_free;

	// Pattern memory
	always_ff @(posedge clk) begin
		if (pat_we)
			pat_mem[AW'(loaded_q)] <= data;
		if (issue)
			pat_rd_q <= pat_mem[AW'(vk_q)];
	end

	// Text window memory
	always_ff @(posedge clk) begin
		if (state_q == S_TEXT)
			win_mem[wr_ptr_q] <= b_q;
		if (win_re)
			win_rd_q <= win_mem[win_ra];
	end

	// Byte holding and verify compare pipeline
	always_ff @(posedge clk) begin
		if (txt_acc) begin
			b_q   <= data;
			eot_q <= end_of_text;
		end
		if (state_q == S_CHECK) begin
			vk_q <= '0;
			va_q <= rhsm_pkg::wrap_sub(wr_ptr_q, m_eff);
		end else if (issue) begin
			vk_q <= vk_q + CW'(1);
			va_q <= rhsm_pkg::wrap_inc(va_q);
		end
		cmp_last_s1 <= (vk_q == m_eff - CW'(1));
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (load_hit) begin
			kind_q  <= rhsm_pkg::KIND_MATCH;
			pos_q   <= tidx_q - HW'(m_eff);
			total_q <= mcnt_q;
			last_q  <= !eot_q;
		end else if (load_end) begin
			kind_q  <= rhsm_pkg::KIND_TOTAL;
			pos_q   <= '0;
			total_q <= mcnt_q;
			last_q  <= 1'b1;
		end
	end

	// Sequencer, hashes and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= CW'(1);
			ph_q        <= '0;
			wh_q        <= '0;
			factor_q    <= HW'(1);
			loaded_q    <= '0;
			tidx_q      <= '0;
			mcnt_q      <= '0;
			wr_ptr_q    <= '0;
			cmp_vld_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Output register: loaded from an emit state, held while stalled
			out_valid_q <= load_hit || load_end || (out_valid_q && out_stall);
			cmp_vld_s1  <= issue;

			// Length write clears pattern and text state
			if (cfg_wr_en) begin
				len_q    <= cfg_wr_data;
				ph_q     <= '0;
				factor_q <= HW'(1);
				loaded_q <= '0;
				wh_q     <= '0;
				tidx_q   <= '0;
				mcnt_q   <= '0;
				wr_ptr_q <= '0;
			end else begin
				case (state_q)
					S_IDLE: begin
						if (pat_we) begin
							ph_q     <= ph_q * rhsm_pkg::HASH_BASE + HW'(data);
							factor_q <= factor_q * rhsm_pkg::HASH_BASE;
							loaded_q <= loaded_q + CW'(1);
						end
						if (txt_acc)
							state_q <= S_TEXT;
					end
					S_TEXT: begin
						wh_q     <= wh_next;
						wr_ptr_q <= rhsm_pkg::wrap_inc(wr_ptr_q);
						tidx_q   <= rhsm_pkg::sat_inc(tidx_q);
						state_q  <= S_CHECK;
					end
					S_CHECK: begin
						if (cand)
							state_q <= S_VERIFY;
						else if (eot_q)
							state_q <= S_EMIT_END;
						else
							state_q <= S_IDLE;
					end
					S_VERIFY: begin
						if (cmp_vld_s1) begin
							if (pat_rd_q != win_rd_q) begin
								state_q <= eot_q ? S_EMIT_END : S_IDLE;
							end else if (cmp_last_s1) begin
								mcnt_q  <= rhsm_pkg::sat_inc(mcnt_q);
								state_q <= S_EMIT_HIT;
							end
						end
					end
					S_EMIT_HIT: begin
						if (out_free)
							state_q <= eot_q ? S_EMIT_END : S_IDLE;
					end
					S_EMIT_END: begin
						if (out_free) begin
							wh_q     <= '0;
							tidx_q   <= '0;
							mcnt_q   <= '0;
							wr_ptr_q <= '0;
							state_q  <= S_IDLE;
						end
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign position    = pos_q;
	assign total       = total_q;
	assign last_of_run = last_q;

	// Checks
	`RHSM_ASSERT(a_out_from_emit, $rose(out_valid_q) |-> ($past(state_q) == S_EMIT_HIT || $past(state_q) == S_EMIT_END), "result raised outside an emit state")
	`RHSM_NEVER(a_loaded_le_len, loaded_q > m_eff, "pattern fill count exceeds pattern length")
	`RHSM_NEVER(a_verify_cnt, (state_q == S_VERIFY) && (vk_q > m_eff), "verify index ran past pattern length")
	`RHSM_ASSERT(a_end_clears, (state_q == S_EMIT_END && out_free) |=> (tidx_q == '0 && mcnt_q == '0), "text counters not cleared after end of text")

endmodule

`default_nettype wire
